/* src/bat_pkg.sv */
// Shared constants, types and node update function for the buddy allocator tree.
package bat_pkg;

    localparam int POOL_ORDER    = 10;
    localparam int POOL_UNITS    = 1 << POOL_ORDER;
    localparam int ORD_W         = 4;
    localparam int NODE_W        = POOL_ORDER + 1;
    localparam int ROW_W         = POOL_ORDER;
    localparam int ROW_COUNT     = POOL_UNITS - 1;
    localparam int REQ_W         = 11;
    localparam int OFF_W         = 10;
    localparam int MAX_ORDER_RST = 10;

    typedef logic [ORD_W-1:0]    t_ord;
    typedef logic [NODE_W-1:0]   t_node;
    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [2*ORD_W-1:0]  t_pair;
    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [OFF_W-1:0]    t_off;

    localparam t_ord ALLOC_MARK = t_ord'(15);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        t_pair pair;
        t_ord  pval;
    } t_upd;

    // Replace one child in a sibling pair and recompute the parent's free order.
    // An allocated mark counts as no free space; a free merges two whole buddies.
    function automatic t_upd f_update(input t_pair pair, input logic slot, input t_ord val,
                                      input t_ord lvl, input logic merge);
        t_upd res;
        t_ord l;
        t_ord r;
        res.pair = pair;
        if (slot) begin
            res.pair[2*ORD_W-1:ORD_W] = val;
        end else begin
            res.pair[ORD_W-1:0] = val;
        end
        l = res.pair[ORD_W-1:0];
        r = res.pair[2*ORD_W-1:ORD_W];
        if (merge && l == lvl && r == lvl) begin
            res.pval = lvl + t_ord'(1);
        end else if (l == ALLOC_MARK) begin
            res.pval = r;
        end else if (r == ALLOC_MARK) begin
            res.pval = l;
        end else begin
            res.pval = (l > r) ? l : r;
        end
        return res;
    endfunction

endpackage

/* src/buddy_allocator_tree_top.sv */
// Binary buddy allocator: free-order tree in a sibling-pair memory with a sequencer.
//
// Input channel (i_in_valid / o_in_ready) carries one item: i_opcode selects
// allocate or free, i_request_units is the alloc size (rounded up to a power of
// two, zero treated as one), i_free_offset the unit offset to release.
// Output channel (o_out_valid / i_out_ready) returns one item per alloc:
// o_granted, o_block_order, o_block_offset (order and offset zero on failure).
// A free returns nothing. i_cfg_we / i_cfg_data write max_alloc_order.
//
// The tree lives in one memory row per inner node holding both children's
// free orders, plus the root in a register. Every level is a registered
// read of a row; on the ascent a row is written back while the next is read.
// Alloc: an accept step, a descent to the block, an ascent rebuilding the
// ancestors and a finish step. A failed alloc or a whole-pool grant goes
// from accept straight to finish. A free climbs from leaf to root. One item
// is worked at a time.
// After reset a fill pass writes the initial orders into all POOL_UNITS-1 = 1023
// rows; o_in_ready stays low meanwhile (config writes still land).
// A finished result sits in the output register until taken; the next item
// is still accepted, and only the following result waits if it is not taken.
module buddy_allocator_tree_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  bat_pkg::t_req        i_request_units,
    input  bat_pkg::t_off        i_free_offset,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_granted,
    output bat_pkg::t_ord        o_block_order,
    output bat_pkg::t_off        o_block_offset,
    input  logic                 i_cfg_we,
    input  bat_pkg::t_ord        i_cfg_data
);
    import bat_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DESC,
        S_UP,
        S_DONE
    } t_state;

    t_state r_state;

    // sibling-pair store: row n holds {right, left} children of node n
    t_pair  mem [0:ROW_COUNT-1];
    t_pair  r_rdata;

    t_ord   r_root;
    t_ord   r_max_order;
    t_row   r_clr_row;
    t_ord   r_clr_val;

    t_node  r_node;      // descent: current node; ascent: child just updated
    t_ord   r_cur;       // height of r_node during descent
    t_ord   r_order;
    t_ord   r_val;       // new free order of r_node during ascent
    t_ord   r_lvl;       // height of r_node during ascent
    logic   r_is_free;

    logic   r_pend;
    logic   r_res_granted;
    t_ord   r_res_order;
    t_off   r_res_offset;

    logic   r_out_valid;
    logic   r_out_granted;
    t_ord   r_out_order;
    t_off   r_out_offset;

    // combinational helpers
    logic   in_acc;
    t_ord   req_order;
    logic   alloc_fail;
    t_node  leaf_node;
    logic   free_ok;
    t_ord   left_val;
    logic   go_left;
    t_node  desc_child;
    t_ord   cur_next;
    logic   desc_found;
    t_node  child_sh;
    t_upd   upd_d;
    t_upd   upd_u;
    t_node  up_parent;
    t_row   rd_addr;
    logic   wr_en;
    t_row   wr_addr;
    t_pair  wr_data;
    t_row   clr_next;
    logic   out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // round request up to a power of two
    always_comb begin
        req_order = '0;
        for (int k = REQ_W; k >= 0; k--) begin
            if (((REQ_W+1)'(1) << k) >= {1'b0, i_request_units}) begin
                req_order = t_ord'(k);
            end
        end
    end

    assign alloc_fail = (req_order > r_max_order) || (req_order > t_ord'(POOL_ORDER)) ||
                        (r_root == ALLOC_MARK) || (r_root < req_order);
    assign leaf_node  = t_node'(i_free_offset) + t_node'(POOL_UNITS - 1);
    assign free_ok    = {1'b0, i_free_offset} < (OFF_W+1)'(POOL_UNITS);

    // descent: pick left child when it holds a large enough free block
    assign left_val   = r_rdata[ORD_W-1:0];
    assign go_left    = (left_val != ALLOC_MARK) && (left_val >= r_order);
    assign desc_child = {r_node[NODE_W-2:0], 1'b0} + (go_left ? t_node'(1) : t_node'(2));
    assign cur_next   = r_cur - t_ord'(1);
    assign desc_found = (cur_next == r_order);
    assign child_sh   = (desc_child + t_node'(1)) << r_order;
    assign upd_d      = f_update(r_rdata, ~desc_child[0], ALLOC_MARK, r_order, 1'b0);

    // ascent: r_node is the child, its row is the parent's pair
    assign up_parent  = (r_node - t_node'(1)) >> 1;
    assign upd_u      = f_update(r_rdata, ~r_node[0], r_val, r_lvl, r_is_free);

    assign clr_next   = r_clr_row + t_row'(1);

    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_row;
                wr_data = {r_clr_val, r_clr_val};
            end
            S_IDLE: begin
                rd_addr = (i_opcode == OP_FREE) ?
                          t_row'((leaf_node - t_node'(1)) >> 1) : '0;
            end
            S_DESC: begin
                if (desc_found) begin
                    wr_en   = 1'b1;
                    wr_addr = t_row'(r_node);
                    wr_data = upd_d.pair;
                    rd_addr = t_row'((r_node - t_node'(1)) >> 1);
                end else begin
                    rd_addr = t_row'(desc_child);
                end
            end
            S_UP: begin
                wr_en   = 1'b1;
                wr_addr = t_row'(up_parent);
                wr_data = upd_u.pair;
                rd_addr = t_row'((up_parent - t_node'(1)) >> 1);
            end
            S_DONE: begin
                rd_addr = '0;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    // tree memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_root      <= t_ord'(POOL_ORDER);
            r_max_order <= t_ord'(MAX_ORDER_RST);
            r_clr_row   <= '0;
            r_clr_val   <= t_ord'(POOL_ORDER - 1);
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_order <= i_cfg_data;
            end
            // taken item drops unless a waiting result reloads the register
            if (r_out_valid && i_out_ready && !(r_state == S_DONE && r_pend)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_row <= clr_next;
                    // children one level deeper once the next row starts a new depth
                    if (((clr_next + t_row'(1)) & clr_next) == '0) begin
                        r_clr_val <= r_clr_val - t_ord'(1);
                    end
                    if (r_clr_row == t_row'(ROW_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_opcode == OP_FREE) begin
                            if (free_ok) begin
                                r_node    <= leaf_node;
                                r_val     <= '0;
                                r_lvl     <= '0;
                                r_is_free <= 1'b1;
                                r_state   <= S_UP;
                            end
                        end else if (alloc_fail) begin
                            r_res_granted <= 1'b0;
                            r_res_order   <= '0;
                            r_res_offset  <= '0;
                            r_pend        <= 1'b1;
                            r_state       <= S_DONE;
                        end else if (req_order == t_ord'(POOL_ORDER)) begin
                            // whole pool
                            r_root        <= ALLOC_MARK;
                            r_res_granted <= 1'b1;
                            r_res_order   <= req_order;
                            r_res_offset  <= '0;
                            r_pend        <= 1'b1;
                            r_state       <= S_DONE;
                        end else begin
                            r_node    <= '0;
                            r_cur     <= t_ord'(POOL_ORDER);
                            r_order   <= req_order;
                            r_is_free <= 1'b0;
                            r_state   <= S_DESC;
                        end
                    end
                end
                S_DESC: begin
                    if (desc_found) begin
                        r_res_granted <= 1'b1;
                        r_res_order   <= r_order;
                        r_res_offset  <= t_off'(child_sh);
                        r_pend        <= 1'b1;
                        if (r_node == '0) begin
                            r_root  <= upd_d.pval;
                            r_state <= S_DONE;
                        end else begin
                            r_val   <= upd_d.pval;
                            r_lvl   <= r_cur;
                            r_state <= S_UP;
                        end
                    end else begin
                        r_node <= desc_child;
                        r_cur  <= cur_next;
                    end
                end
                S_UP: begin
                    if (up_parent == '0) begin
                        r_root  <= upd_u.pval;
                        r_state <= S_DONE;
                    end else begin
                        r_node <= up_parent;
                        r_val  <= upd_u.pval;
                        r_lvl  <= r_lvl + t_ord'(1);
                    end
                end
                S_DONE: begin
                    if (!r_pend) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_granted <= r_res_granted;
                        r_out_order   <= r_res_order;
                        r_out_offset  <= r_res_offset;
                        r_pend        <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_out_granted;
    assign o_block_order  = r_out_order;
    assign o_block_offset = r_out_offset;

endmodule

/* dv/bat_grant_check.sv */
// Grant checker: mirrors the buddy tree, predicts each alloc result and compares it.
`timescale 1ns / 100ps

module bat_grant_check
    import bat_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  logic i_opcode,
    input  t_req i_request_units,
    input  t_off i_free_offset,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  logic i_granted,
    input  t_ord i_block_order,
    input  t_off i_block_offset,
    input  logic i_cfg_we,
    input  t_ord i_cfg_data,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int NODE_CNT = 2 * POOL_UNITS - 1;

    typedef struct packed {
        logic granted;
        t_ord order;
        t_off offset;
    } t_grant;

    t_ord   free_ord [NODE_CNT];
    t_ord   max_ord;
    t_grant grant_q [$];
    t_grant want;
    int     fails = 0;
    int     waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    // free order of a node, allocated counts as -1
    function automatic int room(int node);
        return (free_ord[node] == ALLOC_MARK) ? -1 : int'(free_ord[node]);
    endfunction

    function automatic void set_room(int node, int v);
        free_ord[node] = (v < 0) ? ALLOC_MARK : t_ord'(v);
    endfunction

    function automatic void reset_tree();
        int lvl;
        lvl = POOL_ORDER;
        for (int i = 0; i < NODE_CNT; i++) begin
            if (i != 0 && ((i + 1) & i) == 0) begin
                lvl--;
            end
            free_ord[i] = t_ord'(lvl);
        end
    endfunction

    // leaf cleared, ancestors rebuilt; equal whole buddies merge
    function automatic void release_block(t_off where);
        int node;
        int lvl;
        int l;
        int r;
        if (int'(where) >= POOL_UNITS) begin
            return;
        end
        node = int'(where) + POOL_UNITS - 1;
        lvl  = 0;
        free_ord[node] = '0;
        while (node != 0) begin
            node = (node - 1) / 2;
            l = room(2 * node + 1);
            r = room(2 * node + 2);
            if (l == lvl && r == lvl) begin
                set_room(node, lvl + 1);
            end else begin
                set_room(node, (l > r) ? l : r);
            end
            lvl++;
        end
    endfunction

    function automatic t_grant grant_block(t_req units);
        t_grant g;
        int     ord;
        int     node;
        int     cur;
        int     l;
        int     r;
        g   = '0;
        ord = 0;
        while (ord < 31 && (1 << ord) < int'(units)) begin
            ord++;
        end
        if (ord > int'(max_ord) || ord > POOL_ORDER || room(0) < ord) begin
            return g;
        end
        node = 0;
        for (cur = POOL_ORDER; cur != ord; cur--) begin
            if (room(2 * node + 1) >= ord) begin
                node = 2 * node + 1;
            end else begin
                node = 2 * node + 2;
            end
        end
        g.granted = 1'b1;
        g.order   = t_ord'(ord);
        g.offset  = t_off'(((node + 1) << ord) - POOL_UNITS);
        free_ord[node] = ALLOC_MARK;
        while (node != 0) begin
            node = (node - 1) / 2;
            l = room(2 * node + 1);
            r = room(2 * node + 2);
            set_room(node, (l > r) ? l : r);
        end
        return g;
    endfunction

    task automatic cmp_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_tree();
            max_ord = t_ord'(MAX_ORDER_RST);
            grant_q.delete();
        end else begin
            // result first: it can never belong to an item taken at this edge
            if (i_out_valid && i_out_ready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected item: granted %0d order %0d offset %0d",
                           i_granted, i_block_order, i_block_offset);
                    fails++;
                end else begin
                    want = grant_q.pop_front();
                    cmp_field("granted", want.granted, i_granted);
                    cmp_field("block_order", want.order, i_block_order);
                    cmp_field("block_offset", want.offset, i_block_offset);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_opcode == OP_FREE) begin
                    release_block(i_free_offset);
                end else begin
                    grant_q.push_back(grant_block(i_request_units));
                end
            end
            if (i_cfg_we) begin
                max_ord = i_cfg_data;
            end
        end
        waiting = grant_q.size();
    end

endmodule

/* dv/tb.sv */
// Testbench top: drives alloc/free items and max-order writes into the buddy allocator.
`timescale 1ns / 100ps

module tb;
    import bat_pkg::*;

    // covers the fill pass and about 1.5k items at their slowest, with plenty of slack
    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 370;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        t_ord order;
        t_off offset;
    } t_block;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic opcode = OP_ALLOC;
    t_req req_units = t_req'(1);
    t_off free_off = '0;
    logic out_ready = 1'b1;
    logic cfg_we = 1'b0;
    t_ord cfg_data = '0;

    logic o_in_ready;
    logic o_out_valid;
    logic o_granted;
    t_ord o_block_order;
    t_off o_block_offset;

    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   calm = 1'b0;     // set for the tail of the run: no idling on either side

    // blocks seen granted and not yet picked for a free
    t_block live_q [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    buddy_allocator_tree_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (opcode),
        .i_request_units (req_units),
        .i_free_offset   (free_off),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_granted       (o_granted),
        .o_block_order   (o_block_order),
        .o_block_offset  (o_block_offset),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data)
    );

    bat_grant_check u_grant_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (o_in_ready),
        .i_opcode        (opcode),
        .i_request_units (req_units),
        .i_free_offset   (free_off),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .i_granted       (o_granted),
        .i_block_order   (o_block_order),
        .i_block_offset  (o_block_offset),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Track granted blocks so most frees hit something that is really allocated.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready && o_granted) begin
            live_q.push_back('{o_block_order, o_block_offset});
        end
    end

    // Result side back-pressure: random stall bursts while calm is clear.
    initial begin : out_stall
        int n;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 12);
                out_ready = 1'b0;
                repeat (n) @(negedge i_clk);
                out_ready = 1'b1;
            end
        end
    end

    // Present one item at the falling edge and hold it until the block takes it.
    task automatic send_item(t_op op, t_req units, t_off where);
        @(negedge i_clk);
        in_valid  = 1'b1;
        opcode    = op;
        req_units = units;
        free_off  = where;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                @(negedge i_clk);
                in_valid = 1'b0;
            end
        end
    endtask

    // Register writes only with the block idle. A free gives no result, so after
    // the last result the block may still be rebuilding ancestors:
    // the extra wait covers that.
    task automatic write_max_order(t_ord v);
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_data = v;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    // Mostly small requests so the pool churns; a few span the whole 11-bit field.
    function automatic t_req pick_units();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) begin
            return t_req'($urandom_range(1, 4));
        end else if (p < 85) begin
            return t_req'($urandom_range(1, 32));
        end else if (p < 95) begin
            return t_req'($urandom_range(1, 1024));
        end
        return t_req'($urandom_range(0, 2047));
    endfunction

    // Well-formed traffic: allocs and frees of granted blocks (at any unit inside
    // the block), plus some frees at random offsets and raw request values.
    task automatic random_item();
        int     pick;
        int     idx;
        t_block b;
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 88 && live_q.size() == 0)) begin
            send_item(OP_ALLOC, pick_units(), t_off'($urandom));
        end else if (pick < 88) begin
            idx = $urandom_range(0, live_q.size() - 1);
            b   = live_q[idx];
            live_q.delete(idx);
            send_item(OP_FREE, t_req'($urandom),
                      b.offset + t_off'($urandom_range(0, (1 << b.order) - 1)));
        end else if (pick < 95) begin
            send_item(OP_FREE, t_req'($urandom), t_off'($urandom));
        end else begin
            send_item(OP_ALLOC, t_req'($urandom), t_off'($urandom));
        end
    endtask

    initial begin : stimulus
        t_ord phase_ord [4];
        phase_ord = '{t_ord'(15), t_ord'(2), t_ord'($urandom_range(0, 15)), t_ord'(10)};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, max order at its reset value of 10.
        send_item(OP_ALLOC, t_req'(0), '0);        // zero request acts as one unit
        send_item(OP_ALLOC, t_req'(1), '0);
        send_item(OP_ALLOC, t_req'(2047), '0);     // order 11: beyond the pool
        send_item(OP_ALLOC, t_req'(1024), '0);     // root lacks a whole free pool
        send_item(OP_ALLOC, t_req'(1025), '0);
        send_item(OP_ALLOC, t_req'(3), '0);        // rounds up to 4
        send_item(OP_ALLOC, t_req'(512), '0);
        send_item(OP_FREE, t_req'(0), t_off'(1023)); // free inside the 512 block
        send_item(OP_FREE, t_req'(0), t_off'(0));
        send_item(OP_FREE, t_req'(0), t_off'(1));
        send_item(OP_FREE, t_req'(0), t_off'(5));
        send_item(OP_ALLOC, t_req'(1024), '0);     // whole pool
        send_item(OP_ALLOC, t_req'(1), '0);        // pool full
        send_item(OP_FREE, t_req'(2047), t_off'(700));
        write_max_order(t_ord'(0));
        send_item(OP_ALLOC, t_req'(1), '0);
        send_item(OP_ALLOC, t_req'(2), '0);        // above max order
        write_max_order(t_ord'(15));
        send_item(OP_ALLOC, t_req'(1024), '0);     // one unit in use
        send_item(OP_ALLOC, t_req'(2047), '0);
        send_item(OP_FREE, t_req'(0), t_off'(0));
        send_item(OP_ALLOC, t_req'(1024), '0);
        send_item(OP_FREE, t_req'(0), t_off'(512));

        // Random phases, each behind a drain and a register write; the tail of
        // the last phase runs without idling.
        for (int p = 0; p < 4; p++) begin
            write_max_order(phase_ord[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 3 && n >= ITEMS_PER_PHASE / 2) begin
                    calm = 1'b1;
                end
                random_item();
                sender_gap();
            end
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* buddy_allocator_tree_top.f */
src/bat_pkg.sv
src/buddy_allocator_tree_top.sv
dv/bat_grant_check.sv
dv/tb.sv
